### design/rfdo_pkg.sv
// shared constants and types for the drop-oldest ring fifo
`default_nettype none

package rfdo_pkg;

    // storage geometry, depth must be a power of two
    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // fixed field widths of the stream items
    localparam int OP_W   = 2;
    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;
    localparam int S_TDATA_W = ((OP_W + DATA_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + DATA_W + 1 + OCC_W + 1 + 1;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

    // configuration address map
    localparam int PADDR_W = 3;
    localparam logic REG_DROP_MODE = 1'b0;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

endpackage

`default_nettype wire

### design/ring_fifo_drop_oldest.sv
// ring fifo with optional drop-oldest on push to full, one operation per transaction
// a result is registered and appears in the cycle after its operation is accepted
// throughput: one operation per cycle while the result side keeps up; the single-port
//   read of the entry memory and the one-deep result register set that figure
// reset: pointers, count, drop mode and result valid clear at once; entry memory is
//   not cleared, entries are only read after they were written
`default_nettype none

module ring_fifo_drop_oldest (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // operation stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // opcode[1:0], push_data[33:2], zero pad
    input  wire logic [rfdo_pkg::S_TDATA_W-1:0] s_tdata,
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // ok[0], read_data[32:1], dropped[33], occupancy[38:34], is_empty[39],
    // is_full[40], zero pad
    output logic [rfdo_pkg::M_TDATA_W-1:0]      m_tdata,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rfdo_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import rfdo_pkg::*;

    // control state
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             drop_mode_reg;

    // result register
    logic             out_valid_reg;
    logic             ok_reg, ok_next;
    logic             dropped_reg, dropped_next;
    logic             rd_sel_reg, rd_sel_next;
    logic [CNT_W-1:0] occ_reg;
    logic [WORD_W-1:0] rd_data_reg;

    // entry memory
    logic [WORD_W-1:0] mem [DEPTH];
    logic              mem_we;
    logic              mem_re;

    // decoded operation
    logic              accept;
    op_t               op;
    logic [WORD_W-1:0] word;
    logic              full;
    logic              empty;
    logic [DATA_W-1:0] read_data;
    logic [OCC_W-1:0]  occupancy;

    assign op     = op_t'(s_tdata[OP_W-1:0]);
    assign word   = WORD_W'(s_tdata[OP_W +: DATA_W]);
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    // take a new operation whenever the result slot frees up this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // apb port, writes land on the access phase
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DROP_MODE) ? {31'b0, drop_mode_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_DROP_MODE))
        begin
            drop_mode_reg <= pwdata[0];
        end
    end

    // operation decode and pointer update
    always_comb
    begin
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        count_next   = count_reg;
        ok_next      = 1'b0;
        dropped_next = 1'b0;
        rd_sel_next  = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        case (op)
            OP_PUSH:
            begin
                if (!full)
                begin
                    mem_we     = 1'b1;
                    wp_next    = wp_reg + PTR_W'(1);
                    count_next = count_reg + CNT_W'(1);
                    ok_next    = 1'b1;
                end
                else if (drop_mode_reg)
                begin
                    // discard the oldest, count stays at depth
                    mem_we       = 1'b1;
                    wp_next      = wp_reg + PTR_W'(1);
                    rp_next      = rp_reg + PTR_W'(1);
                    ok_next      = 1'b1;
                    dropped_next = 1'b1;
                end
            end
            OP_POP:
            begin
                if (!empty)
                begin
                    mem_re      = 1'b1;
                    rp_next     = rp_reg + PTR_W'(1);
                    count_next  = count_reg - CNT_W'(1);
                    ok_next     = 1'b1;
                    rd_sel_next = 1'b1;
                end
            end
            OP_PEEK:
            begin
                if (!empty)
                begin
                    mem_re      = 1'b1;
                    ok_next     = 1'b1;
                    rd_sel_next = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                wp_next    = '0;
                rp_next    = '0;
                count_next = '0;
                ok_next    = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
        if (!accept)
        begin
            mem_we = 1'b0;
            mem_re = 1'b0;
        end
    end

    // pointer, count and result control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            dropped_reg   <= 1'b0;
            rd_sel_reg    <= 1'b0;
            occ_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg        <= wp_next;
                rp_reg        <= rp_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
                ok_reg        <= ok_next;
                dropped_reg   <= dropped_next;
                rd_sel_reg    <= rd_sel_next;
                occ_reg       <= count_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= word;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rp_reg];
        end
    end

    // result packing
    assign read_data = rd_sel_reg ? DATA_W'(rd_data_reg) : '0;
    assign occupancy = OCC_W'(occ_reg);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = M_TDATA_W'({(occ_reg == CNT_W'(DEPTH)),
                                   (occ_reg == '0),
                                   occupancy,
                                   dropped_reg,
                                   read_data,
                                   ok_reg});

`ifndef SYNTHESIS
    // count never passes depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // pointer distance tracks the count
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg - rp_reg) == count_reg[PTR_W-1:0])
        else $error("pointer distance disagrees with count");

    // a drop only happens on a successful push that leaves the fifo full
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dropped_reg) |-> (ok_reg && (occ_reg == CNT_W'(DEPTH))))
        else $error("drop reported without full fifo");

    // read data is only selected for a successful read
    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rd_sel_reg) |-> (ok_reg && !dropped_reg))
        else $error("read data selected on a failed operation");
`endif

endmodule

`default_nettype wire
